// ===== rtl/cgl_pkg.sv =====
// shared types and constants for the glyph lookup block
package cgl_pkg;
  localparam int MaxSegments = 256;
  localparam int GlyphWords = 1024;
  localparam int SegIdxW = $clog2(MaxSegments);
  localparam int SegCntW = SegIdxW + 1;
  localparam int GlyphIdxW = $clog2(GlyphWords);
  localparam int CodeW = 21;

  localparam logic [1:0] CMD_LOAD_SEG = 2'd0;
  localparam logic [1:0] CMD_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] FMT_SEG4 = 2'd1;
  localparam logic [1:0] FMT_SEG12 = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;

  typedef struct packed {
    logic [CodeW-1:0] lo_code;
    logic [CodeW-1:0] hi_code;
    logic [15:0] seg_value;
    logic [15:0] range_offset;
  } seg_t;

  // token travelling down the cell chain
  typedef struct packed {
    logic vld;
    logic done;
    logic hit;
    logic [SegIdxW-1:0] seg;
    seg_t seg_data;
  } tok_t;
endpackage

// ===== rtl/cgl_cell.sv =====
// one segment cell: holds a segment and checks the passing token
module cgl_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cgl_pkg::seg_t wr_data,
  input  logic [cgl_pkg::SegIdxW-1:0] my_idx,
  input  logic [cgl_pkg::SegCntW-1:0] live_cnt,
  input  logic fmt4,
  input  logic [cgl_pkg::CodeW-1:0] code,
  input  cgl_pkg::tok_t tok_in,
  output cgl_pkg::tok_t tok_out
);
  cgl_pkg::seg_t seg_r;
  cgl_pkg::tok_t tok_nxt;
  logic active;
  logic inside_rng;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_r <= wr_data;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    active = tok_in.vld && !tok_in.done && ({1'b0, my_idx} < live_cnt);
    inside_rng = (seg_r.lo_code <= code) && (seg_r.hi_code >= code);
    if (active) begin
      if (fmt4 && seg_r.hi_code == 21'h00FFFF) begin
        tok_nxt.done = 1'b1;
      end else if (inside_rng) begin
        tok_nxt.done = 1'b1;
        tok_nxt.hit = 1'b1;
        tok_nxt.seg = my_idx;
        tok_nxt.seg_data = seg_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_nxt;
    end
  end
endmodule

// ===== rtl/cmap_glyph_lookup.sv =====
// top level: cell chain segment search, glyph word store and result stage
// a lookup passes start_r, each cell register, then the result registers
// a hit that reads the glyph store also passes S_READ before its result
// loads give no result and can follow each other back to back
// a waiting result holds the input; the next transfer waits until ovalid_r clears
// rst_n clears control and tokens; data regs, segment and glyph stores are not
module cmap_glyph_lookup (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_cmd,
  input  logic [9:0] in_entry_index,
  input  logic [20:0] in_start_code,
  input  logic [20:0] in_end_code,
  input  logic [15:0] in_seg_value,
  input  logic [15:0] in_range_offset,
  input  logic [15:0] in_glyph_word,
  input  logic [20:0] in_code_point,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] out_glyph_index,
  output logic [1:0] out_status,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  localparam int N = cgl_pkg::MaxSegments;
  localparam int SW = cgl_pkg::SegIdxW;
  localparam int CW = cgl_pkg::SegCntW;
  localparam int GW = cgl_pkg::GlyphIdxW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_READ = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] fmt_r;
  logic [8:0] cnt_r;
  logic [CW-1:0] live_cnt;
  logic [20:0] code_r;
  logic [1:0] lfmt_r;
  logic [15:0] gly_r;
  logic [1:0] st_r;
  logic ovalid_r;
  logic start_r;
  logic [15:0] glyph_mem [cgl_pkg::GlyphWords];
  logic [15:0] rd_word_r;
  logic [15:0] delta_r;
  logic in_acc;
  logic cfg_wr;
  cgl_pkg::tok_t chain [N+1];
  cgl_pkg::tok_t head;
  cgl_pkg::seg_t wr_seg;
  cgl_pkg::tok_t tail;
  logic signed [19:0] addr;
  logic [15:0] diff;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == cgl_pkg::REG_COUNT[0]) ? {23'd0, cnt_r}
                                                           : {30'd0, fmt_r};
  assign live_cnt = (cnt_r > 9'(N)) ? CW'(N) : CW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= '0;
      cnt_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == cgl_pkg::REG_FORMAT[0]) begin
        fmt_r <= cfg_pwdata[1:0];
      end else begin
        cnt_r <= cfg_pwdata[8:0];
      end
    end
  end

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_acc = in_valid && in_ready;
  assign wr_seg = '{lo_code: in_start_code, hi_code: in_end_code,
                    seg_value: in_seg_value, range_offset: in_range_offset};

  always_comb begin
    head = '0;
    head.vld = start_r;
  end
  assign chain[0] = head;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cgl_cell u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .wr_en(in_acc && in_cmd == cgl_pkg::CMD_LOAD_SEG &&
             in_entry_index == 10'(i)),
      .wr_data(wr_seg),
      .my_idx(SW'(i)),
      .live_cnt(live_cnt),
      .fmt4(lfmt_r == cgl_pkg::FMT_SEG4),
      .code(code_r),
      .tok_in(chain[i]),
      .tok_out(chain[i+1])
    );
  end
  assign tail = chain[N];

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == cgl_pkg::CMD_LOAD_GLYPH &&
        11'(in_entry_index) < 11'(cgl_pkg::GlyphWords)) begin
      glyph_mem[in_entry_index[GW-1:0]] <= in_glyph_word;
    end
  end

  assign diff = 16'(code_r - tail.seg_data.lo_code);
  assign addr = 20'(tail.seg_data.range_offset[15:1]) + 20'(diff) + 20'(tail.seg)
              - 20'(live_cnt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && in_cmd == cgl_pkg::CMD_LOOKUP) state_nxt = S_SCAN;
      S_SCAN: if (tail.vld) state_nxt = S_IDLE;
      S_READ: state_nxt = S_IDLE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SCAN && tail.vld && lfmt_r == cgl_pkg::FMT_SEG4 &&
        code_r <= 21'h00FFFF && tail.hit && tail.seg_data.range_offset != 16'd0 &&
        !(addr < 0 || addr >= 20'sd1024)) begin
      state_nxt = S_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc && in_cmd == cgl_pkg::CMD_LOOKUP;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      if (state_r == S_READ) ovalid_r <= 1'b1;
      if (state_r == S_SCAN && tail.vld && state_nxt == S_IDLE) ovalid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == cgl_pkg::CMD_LOOKUP) begin
      code_r <= in_code_point;
      lfmt_r <= fmt_r;
    end
    if (state_r == S_SCAN) begin
      rd_word_r <= glyph_mem[addr[GW-1:0]];
      delta_r <= tail.seg_data.seg_value;
    end
    if (state_r == S_READ) begin
      gly_r <= (rd_word_r == 16'd0) ? 16'd0 : rd_word_r + delta_r;
      st_r <= cgl_pkg::ST_OK;
    end else if (state_r == S_SCAN && tail.vld) begin
      gly_r <= 16'd0;
      st_r <= cgl_pkg::ST_OK;
      if (lfmt_r == cgl_pkg::FMT_SEG4) begin
        if (code_r <= 21'h00FFFF && tail.hit) begin
          if (tail.seg_data.range_offset == 16'd0) begin
            gly_r <= code_r[15:0] + tail.seg_data.seg_value;
          end else if (addr < 0 || addr >= 20'sd1024) begin
            st_r <= cgl_pkg::ST_RANGE;
          end
        end
      end else if (lfmt_r == cgl_pkg::FMT_SEG12) begin
        if (tail.hit) begin
          gly_r <= tail.seg_data.seg_value + diff;
        end else begin
          st_r <= cgl_pkg::ST_NOT_FOUND;
        end
      end else begin
        st_r <= cgl_pkg::ST_UNSUPPORTED;
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_glyph_index = gly_r;
  assign out_status = st_r;

`ifndef SYNTHESIS
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_glyph_index)))
    else $error("result dropped");
`endif
endmodule
